@@ rtl/smd_pkg.sv @@
// shared constants, codes and widths for the sine microstep driver
package smd_pkg;

  localparam int TABLE_SIZE_DEF = 3600;

  localparam int OPCODE_W   = 1;
  localparam int STEPS_W    = 16;
  localparam int PERIOD_W   = 24;
  localparam int AMP_W      = 8;
  localparam int HOLD_W     = 20;
  localparam int POS_W      = 32;
  localparam int PIN_W      = 4;
  localparam int ROM_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(5000);
  localparam logic [AMP_W-1:0]    AMP_RST    = AMP_W'(200);
  localparam logic [HOLD_W-1:0]   HOLD_RST   = HOLD_W'(100000);

  localparam logic [OPCODE_W-1:0] OP_TICK = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_MOVE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 2'd2;

  // pi in q30 and the taylor denominators (2n)(2n+1)
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DEN [1:7] = '{6, 20, 42, 72, 110, 156, 210};

endpackage

@@ rtl/smd_in_if.sv @@
// command channel: tick or move beat
interface smd_in_if;
  logic                                valid;
  logic                                ready;
  logic [smd_pkg::OPCODE_W-1:0]        opcode;
  logic signed [smd_pkg::STEPS_W-1:0]  move_steps;

  modport source (output valid, output opcode, output move_steps, input ready);
  modport sink   (input valid, input opcode, input move_steps, output ready);
endinterface

@@ rtl/smd_out_if.sv @@
// result channel: dac levels, coil pins and position
interface smd_out_if;
  logic                               valid;
  logic                               ready;
  logic [smd_pkg::AMP_W-1:0]          dac_a;
  logic [smd_pkg::AMP_W-1:0]          dac_b;
  logic [smd_pkg::PIN_W-1:0]          coil_pins;
  logic                               busy_res;
  logic signed [smd_pkg::POS_W-1:0]   step_position;

  modport source (output valid, output dac_a, output dac_b, output coil_pins,
                  output busy_res, output step_position, input ready);
  modport sink   (input valid, input dac_a, input dac_b, input coil_pins,
                  input busy_res, input step_position, output ready);
endinterface

@@ rtl/smd_sine_rom.sv @@
// half-sine rom, built at elaboration, registered read
module smd_sine_rom #(
  parameter int TABLE_SIZE = smd_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
  output logic [smd_pkg::ROM_W-1:0]     rd_data
);

  typedef logic [smd_pkg::ROM_W-1:0] rom_t [TABLE_SIZE];

  function automatic rom_t build_rom();
    rom_t              rom;
    longint unsigned   k;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   r;
    longint            sum;
    int                i;
    int                n;
    for (i = 0; i < TABLE_SIZE; i++) begin
      k = 64'(i);
      if (2 * k > 64'(TABLE_SIZE)) k = 64'(TABLE_SIZE) - k;
      x    = smd_pkg::PI_Q30 * k / 64'(TABLE_SIZE);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / smd_pkg::TAYLOR_DEN[n];
        if (n[0]) sum = sum - signed'(term);
        else      sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      r = (unsigned'(sum) + 64'd8192) >> 14;
      if (r > 64'd65536) r = 64'd65536;
      rom[i] = smd_pkg::ROM_W'(r);
    end
    return rom;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [smd_pkg::ROM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sine_microstep_driver.sv @@
// two-coil stepper driver with sine microstepping, top level
//
// in_ch carries one beat per command: opcode tick advances motor time by
// one tick, opcode move loads a signed full-step count. every command beat
// yields exactly one out_ch beat with both dac levels, the coil pins, the
// busy flag and the signed step position.
// cfg_we/cfg_idx/cfg_wdata write step_period, amplitude and hold_ticks;
// write them only while no command is in flight.
// a move, hold, idle or step tick goes straight to the emit state, which
// loads the output register once out_ch can take it, and the sequencer
// then returns to idle for the next command. a microstep tick first runs
// the restoring divider, one quotient bit per cycle, then address wrap,
// two reads of the single rom port and the multiplier before the emit
// state loads the output register.
// in_ch.ready is high only while the sequencer is idle; a finished result
// sits in the output register, and the next command is taken while it
// waits. if out_ch stalls, the following result waits in the sequencer.
// reset (rst_n low, synchronous) loads the register defaults, clears the
// motion state and empties the output register. the rom is a constant
// table and needs no fill.
module sine_microstep_driver #(
  parameter int TABLE_SIZE = smd_pkg::TABLE_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  smd_in_if.sink                           in_ch,
  smd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [smd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [smd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AIW  = $clog2(TABLE_SIZE);
  localparam int QW   = AIW;
  localparam int CW   = $clog2(TABLE_SIZE + 1);
  localparam int NUMW = smd_pkg::PERIOD_W + CW;
  localparam int DSW  = smd_pkg::PERIOD_W + QW;
  localparam int AW   = AIW + 4;
  localparam int CNTW = $clog2(QW);
  localparam int HALF = TABLE_SIZE / 2;

  localparam logic signed [AW-1:0] K_N      = AW'(TABLE_SIZE);
  localparam logic signed [AW-1:0] K_HALF   = AW'(HALF);
  localparam logic signed [AW-1:0] K_NHALF  = AW'(-HALF);
  localparam logic signed [AW-1:0] K_NN     = AW'(-TABLE_SIZE);
  localparam logic signed [AW-1:0] K_N3H    = AW'(-((3 * TABLE_SIZE) / 2));
  localparam logic signed [AW-1:0] K_FWD1   = AW'((1 * TABLE_SIZE) / 2);
  localparam logic signed [AW-1:0] K_FWD2   = AW'((2 * TABLE_SIZE) / 2);
  localparam logic signed [AW-1:0] K_FWD3   = AW'((3 * TABLE_SIZE) / 2);
  localparam logic signed [AW-1:0] K_BWD0   = AW'(1 * HALF);
  localparam logic signed [AW-1:0] K_BWD1   = AW'(2 * HALF);
  localparam logic signed [AW-1:0] K_BWD2   = AW'(3 * HALF);
  localparam logic signed [AW-1:0] K_BWD3   = AW'(4 * HALF);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_ADDR = 7'b0000100,
    ST_RDA  = 7'b0001000,
    ST_RDB  = 7'b0010000,
    ST_MUL  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  // addresses fall within one table length of the valid range
  function automatic logic [AIW-1:0] wrap_addr(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    t = v;
    if (t < 0) t = t + K_N;
    else if (t >= K_N) t = t - K_N;
    return t[AIW-1:0];
  endfunction

  state_t                           state_r, state_nxt;
  logic [smd_pkg::PERIOD_W-1:0]     step_period_r;
  logic [smd_pkg::AMP_W-1:0]        amp_r;
  logic [smd_pkg::HOLD_W-1:0]       hold_ticks_r;

  logic                             moving_r, moving_nxt;
  logic                             holding_r, holding_nxt;
  logic                             forward_r, forward_nxt;
  logic [smd_pkg::STEPS_W-1:0]      steps_rem_r, steps_rem_nxt;
  logic [smd_pkg::POS_W-1:0]        step_cnt_r, step_cnt_nxt;
  logic [smd_pkg::PERIOD_W-1:0]     elapsed_r, elapsed_nxt;
  logic [smd_pkg::HOLD_W-1:0]       hold_cnt_r, hold_cnt_nxt;
  logic [smd_pkg::PIN_W-1:0]        pin_r, pin_nxt;
  logic [2*smd_pkg::AMP_W-1:0]      dac_r, dac_nxt;

  logic [NUMW-1:0]                  rem_r, rem_nxt;
  logic [DSW-1:0]                   dsh_r, dsh_nxt;
  logic [QW-1:0]                    quo_r, quo_nxt;
  logic [CNTW-1:0]                  bit_r, bit_nxt;
  logic [AIW-1:0]                   addr_a_r, addr_a_nxt;
  logic [AIW-1:0]                   addr_b_r, addr_b_nxt;
  logic [smd_pkg::AMP_W-1:0]        va_r, va_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [smd_pkg::AMP_W-1:0]        out_dac_a_r, out_dac_b_r;
  logic [smd_pkg::PIN_W-1:0]        out_pins_r;
  logic                             out_busy_r;
  logic [smd_pkg::POS_W-1:0]        out_pos_r;
  logic                             out_load;

  logic [smd_pkg::PERIOD_W-1:0]     per;
  logic [1:0]                       phase;
  logic                             rom_en;
  logic [AIW-1:0]                   rom_addr;
  logic [smd_pkg::ROM_W-1:0]        rom_data;
  logic [smd_pkg::AMP_W+smd_pkg::ROM_W-1:0] prod;
  logic [smd_pkg::AMP_W-1:0]        tval;
  logic                             div_ge;

  smd_sine_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rom_en),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  assign per      = (step_period_r == '0) ? smd_pkg::PERIOD_W'(1) : step_period_r;
  assign phase    = step_cnt_r[1:0];
  assign rom_en   = (state_r == ST_RDA) || (state_r == ST_RDB);
  assign rom_addr = (state_r == ST_RDA) ? addr_a_r : addr_b_r;
  assign prod     = (smd_pkg::AMP_W + smd_pkg::ROM_W)'(amp_r) *
                    (smd_pkg::AMP_W + smd_pkg::ROM_W)'(rom_data);
  assign tval     = prod[smd_pkg::AMP_W+15:16];
  assign div_ge   = rem_r >= NUMW'(dsh_r);

  always_comb begin
    logic [smd_pkg::STEPS_W-1:0]  raw;
    logic [smd_pkg::STEPS_W-1:0]  sr_dec;
    logic [smd_pkg::POS_W-1:0]    cnt_fin;
    logic [smd_pkg::HOLD_W-1:0]   hc_inc;
    logic [smd_pkg::PERIOD_W-1:0] el_sub;
    logic [QW-1:0]                pos;
    logic signed [AW-1:0]         idx;
    logic signed [AW-1:0]         off_a;
    logic signed [AW-1:0]         off_b;

    state_nxt     = state_r;
    moving_nxt    = moving_r;
    holding_nxt   = holding_r;
    forward_nxt   = forward_r;
    steps_rem_nxt = steps_rem_r;
    step_cnt_nxt  = step_cnt_r;
    elapsed_nxt   = elapsed_r;
    hold_cnt_nxt  = hold_cnt_r;
    pin_nxt       = pin_r;
    dac_nxt       = dac_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    bit_nxt       = bit_r;
    addr_a_nxt    = addr_a_r;
    addr_b_nxt    = addr_b_r;
    va_nxt        = va_r;
    out_load      = 1'b0;

    raw     = unsigned'(in_ch.move_steps);
    sr_dec  = steps_rem_r - smd_pkg::STEPS_W'(1);
    cnt_fin = forward_r ? step_cnt_r + smd_pkg::POS_W'(1) : step_cnt_r;
    hc_inc  = hold_cnt_r + smd_pkg::HOLD_W'(1);
    el_sub  = elapsed_r - per;
    pos     = (quo_r == '0) ? QW'(1) : quo_r;
    idx     = '0;
    off_a   = '0;
    off_b   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EMIT;
          if (in_ch.opcode == smd_pkg::OP_MOVE) begin
            moving_nxt   = 1'b0;
            holding_nxt  = 1'b0;
            elapsed_nxt  = '0;
            hold_cnt_nxt = '0;
            if (raw != '0) begin
              forward_nxt   = ~raw[smd_pkg::STEPS_W-1];
              steps_rem_nxt = raw[smd_pkg::STEPS_W-1] ? smd_pkg::STEPS_W'(0) - raw : raw;
              if (raw[smd_pkg::STEPS_W-1]) begin
                step_cnt_nxt = step_cnt_r - smd_pkg::POS_W'(1);
              end
              moving_nxt = 1'b1;
            end
          end else if (holding_r) begin
            hold_cnt_nxt = hc_inc;
            if (hc_inc >= hold_ticks_r) begin
              holding_nxt = 1'b0;
              dac_nxt     = '0;
            end
          end else if (moving_r) begin
            if (elapsed_r >= per) begin
              steps_rem_nxt = sr_dec;
              if (sr_dec == '0) begin
                // last step: full current on one coil, then hold (zero current if hold_ticks is 0)
                step_cnt_nxt = cnt_fin;
                elapsed_nxt  = el_sub;
                dac_nxt      = cnt_fin[0] ? {smd_pkg::AMP_W'(0), amp_r}
                                          : {amp_r, smd_pkg::AMP_W'(0)};
                moving_nxt   = 1'b0;
                holding_nxt  = (hold_ticks_r != '0);
                hold_cnt_nxt = '0;
                if (hold_ticks_r == '0) dac_nxt = '0;
              end else begin
                step_cnt_nxt = forward_r ? step_cnt_r + smd_pkg::POS_W'(1)
                                         : step_cnt_r - smd_pkg::POS_W'(1);
                elapsed_nxt  = (el_sub == '1) ? el_sub : el_sub + smd_pkg::PERIOD_W'(1);
              end
            end else begin
              // microstep: divide elapsed*N by 2*period
              elapsed_nxt = (elapsed_r == '1) ? elapsed_r
                                              : elapsed_r + smd_pkg::PERIOD_W'(1);
              rem_nxt     = NUMW'(elapsed_r) * NUMW'(TABLE_SIZE);
              dsh_nxt     = DSW'({per, 1'b0}) << (QW - 1);
              quo_nxt     = '0;
              bit_nxt     = CNTW'(QW - 1);
              state_nxt   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_ge) rem_nxt = rem_r - NUMW'(dsh_r);
        quo_nxt = {quo_r[QW-2:0], div_ge};
        dsh_nxt = dsh_r >> 1;
        bit_nxt = bit_r - CNTW'(1);
        if (bit_r == '0) state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        if (forward_r) begin
          case (phase)
            2'd0:    idx = AW'(pos);
            2'd1:    idx = AW'(pos) + K_FWD1;
            2'd2:    idx = AW'(pos) + K_FWD2;
            default: idx = AW'(pos) + K_FWD3;
          endcase
        end else begin
          case (phase)
            2'd0:    idx = K_BWD0 - AW'(pos);
            2'd1:    idx = K_BWD1 - AW'(pos);
            2'd2:    idx = K_BWD2 - AW'(pos);
            default: idx = K_BWD3 - AW'(pos);
          endcase
        end
        case (phase)
          2'd0:    begin off_a = '0;   off_b = K_HALF;  end
          2'd1:    begin off_a = '0;   off_b = K_NHALF; end
          2'd2:    begin off_a = K_NN; off_b = K_NHALF; end
          default: begin off_a = K_NN; off_b = K_N3H;   end
        endcase
        addr_a_nxt = wrap_addr(idx + off_a);
        addr_b_nxt = wrap_addr(idx + off_b);
        state_nxt  = ST_RDA;
      end
      ST_RDA: begin
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        va_nxt    = tval;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        pin_nxt = '0;
        pin_nxt[{1'b0, phase[1]}]             = (va_r != '0);
        pin_nxt[{1'b1, ~(phase[0] ^ phase[1])}] = (tval != '0);
        dac_nxt   = {tval, va_r};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_period_r <= smd_pkg::PERIOD_RST;
      amp_r         <= smd_pkg::AMP_RST;
      hold_ticks_r  <= smd_pkg::HOLD_RST;
      moving_r      <= 1'b0;
      holding_r     <= 1'b0;
      forward_r     <= 1'b1;
      steps_rem_r   <= '0;
      step_cnt_r    <= '0;
      elapsed_r     <= '0;
      hold_cnt_r    <= '0;
      pin_r         <= '0;
      dac_r         <= '0;
      bit_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      moving_r    <= moving_nxt;
      holding_r   <= holding_nxt;
      forward_r   <= forward_nxt;
      steps_rem_r <= steps_rem_nxt;
      step_cnt_r  <= step_cnt_nxt;
      elapsed_r   <= elapsed_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      pin_r       <= pin_nxt;
      dac_r       <= dac_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          smd_pkg::REG_STEP_PERIOD: step_period_r <= cfg_wdata[smd_pkg::PERIOD_W-1:0];
          smd_pkg::REG_AMPLITUDE:   amp_r         <= cfg_wdata[smd_pkg::AMP_W-1:0];
          smd_pkg::REG_HOLD_TICKS:  hold_ticks_r  <= cfg_wdata[smd_pkg::HOLD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    quo_r    <= quo_nxt;
    addr_a_r <= addr_a_nxt;
    addr_b_r <= addr_b_nxt;
    va_r     <= va_nxt;
    if (out_load) begin
      out_dac_a_r <= dac_r[smd_pkg::AMP_W-1:0];
      out_dac_b_r <= dac_r[2*smd_pkg::AMP_W-1:smd_pkg::AMP_W];
      out_pins_r  <= pin_r;
      out_busy_r  <= moving_r | holding_r;
      out_pos_r   <= step_cnt_r;
    end
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.dac_a         = out_dac_a_r;
  assign out_ch.dac_b         = out_dac_b_r;
  assign out_ch.coil_pins     = out_pins_r;
  assign out_ch.busy_res      = out_busy_r;
  assign out_ch.step_position = signed'(out_pos_r);

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the sine microstep driver with an internal motor model
module testbench;

  localparam int TBL = smd_pkg::TABLE_SIZE_DEF;
  localparam int HALF = TBL / 2;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0]  dac_a;
    logic [7:0]  dac_b;
    logic [3:0]  pins;
    logic        busy;
    logic [31:0] pos;
  } coil_drive_t;

  typedef enum {PER_TINY, PER_MID, PER_LARGE} period_band_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [smd_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [smd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  smd_in_if cmd_ch();
  smd_out_if drive_ch();

  sine_microstep_driver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cmd_ch),
    .out_ch    (drive_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [16:0] half_sine [0:TBL-1];

  logic [23:0] mtr_period;
  logic [7:0]  mtr_amp;
  logic [19:0] mtr_hold;
  logic        mtr_moving;
  logic        mtr_holding;
  logic        mtr_fwd;
  logic [15:0] mtr_left;
  logic [31:0] mtr_pos;
  logic [23:0] mtr_elapsed;
  logic [19:0] mtr_hold_cnt;
  logic [3:0]  mtr_pins;
  logic [7:0]  mtr_dac_a;
  logic [7:0]  mtr_dac_b;

  coil_drive_t drive_expected[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned sink_wait = 0;
  bit src_calm = 1'b0;
  bit snk_calm = 1'b0;

  // q30 taylor series on the folded angle, rounded to 16 fraction bits
  initial begin : build_half_sine
    longint unsigned k, x, x2, term, r;
    longint sum;
    int i, n;
    for (i = 0; i < TBL; i++) begin
      k = i;
      if (2 * k > TBL) k = TBL - k;
      x = smd_pkg::PI_Q30 * k / TBL;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (unsigned'(sum) + 64'd8192) >> 14;
      if (r > 65536) r = 65536;
      half_sine[i] = r[16:0];
    end
  end

  function automatic logic [7:0] sine_level(longint idx);
    longint m;
    m = idx % TBL;
    if (m < 0) m += TBL;
    return 8'((longint'(mtr_amp) * longint'(half_sine[m])) >> 16);
  endfunction

  function automatic void microstep_levels();
    longint per, pos, idx, ph;
    logic [7:0] s0, s1, s2, s3;
    per = (mtr_period == 0) ? 1 : longint'(mtr_period);
    ph = longint'(mtr_pos[1:0]);
    pos = (longint'(mtr_elapsed) * TBL) / (2 * per);
    if (pos == 0) pos = 1;
    idx = mtr_fwd ? pos + ph * TBL / 2 : (ph + 1) * HALF - pos;
    s0 = '0;
    s1 = '0;
    s2 = '0;
    s3 = '0;
    case (mtr_pos[1:0])
      2'd0: begin
        s0 = sine_level(idx);
        s3 = sine_level(HALF + idx);
        mtr_dac_a = s0;
        mtr_dac_b = s3;
      end
      2'd1: begin
        s0 = sine_level(idx);
        s2 = sine_level(idx - HALF);
        mtr_dac_a = s0;
        mtr_dac_b = s2;
      end
      2'd2: begin
        s1 = sine_level(idx - TBL);
        s2 = sine_level(idx - HALF);
        mtr_dac_a = s1;
        mtr_dac_b = s2;
      end
      default: begin
        s1 = sine_level(idx - TBL);
        s3 = sine_level(idx - TBL * 3 / 2);
        mtr_dac_a = s1;
        mtr_dac_b = s3;
      end
    endcase
    mtr_pins = {s3 != 0, s2 != 0, s1 != 0, s0 != 0};
  endfunction

  function automatic void motor_tick();
    logic [23:0] per;
    per = (mtr_period == 0) ? 24'd1 : mtr_period;
    if (mtr_holding) begin
      mtr_hold_cnt = mtr_hold_cnt + 20'd1;
      if (mtr_hold_cnt >= mtr_hold) begin
        mtr_holding = 1'b0;
        mtr_dac_a = '0;
        mtr_dac_b = '0;
      end
      return;
    end
    if (!mtr_moving) return;
    if (mtr_elapsed >= per) begin
      mtr_left = mtr_left - 16'd1;
      mtr_pos = mtr_fwd ? mtr_pos + 32'd1 : mtr_pos - 32'd1;
      mtr_elapsed = mtr_elapsed - per;
      if (mtr_left == 0) begin
        if (!mtr_fwd) mtr_pos = mtr_pos + 32'd1;
        // full current on coil b for even phases, on coil a for odd ones
        mtr_dac_a = mtr_pos[0] ? mtr_amp : 8'd0;
        mtr_dac_b = mtr_pos[0] ? 8'd0 : mtr_amp;
        mtr_moving = 1'b0;
        mtr_holding = 1'b1;
        mtr_hold_cnt = '0;
        if (mtr_hold == 0) begin
          mtr_holding = 1'b0;
          mtr_dac_a = '0;
          mtr_dac_b = '0;
        end
        return;
      end
    end else begin
      microstep_levels();
    end
    if (mtr_elapsed != 24'hFFFFFF) mtr_elapsed = mtr_elapsed + 24'd1;
  endfunction

  function automatic coil_drive_t motor_next(logic [smd_pkg::OPCODE_W-1:0] op,
                                             logic [15:0] raw);
    logic [15:0] mag;
    coil_drive_t res;
    if (op == smd_pkg::OP_MOVE) begin
      mag = raw[15] ? 16'(16'd0 - raw) : raw;
      mtr_moving = 1'b0;
      mtr_holding = 1'b0;
      mtr_elapsed = '0;
      mtr_hold_cnt = '0;
      if (mag != 0) begin
        mtr_fwd = !raw[15];
        if (raw[15]) mtr_pos = mtr_pos - 32'd1;
        mtr_left = mag;
        mtr_moving = 1'b1;
      end
    end else begin
      motor_tick();
    end
    res.dac_a = mtr_dac_a;
    res.dac_b = mtr_dac_b;
    res.pins = mtr_pins;
    res.busy = mtr_moving || mtr_holding;
    res.pos = mtr_pos;
    return res;
  endfunction

  task automatic send_cmd(input logic [smd_pkg::OPCODE_W-1:0] op,
                          input logic signed [15:0] steps);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.opcode <= op;
    cmd_ch.move_steps <= steps;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    drive_expected.push_back(motor_next(op, steps));
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [23:0] period, input logic [7:0] amp,
                          input logic [19:0] hold);
    cfg_we <= 1'b1;
    cfg_idx <= smd_pkg::REG_STEP_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_idx <= smd_pkg::REG_AMPLITUDE;
    cfg_wdata <= smd_pkg::CFG_DATA_W'(amp);
    @(posedge clk);
    cfg_idx <= smd_pkg::REG_HOLD_TICKS;
    cfg_wdata <= smd_pkg::CFG_DATA_W'(hold);
    @(posedge clk);
    cfg_we <= 1'b0;
    mtr_period = period;
    mtr_amp = amp;
    mtr_hold = hold;
  endtask

  task automatic check_drive_beat();
    coil_drive_t got, want;
    got.dac_a = drive_ch.dac_a;
    got.dac_b = drive_ch.dac_b;
    got.pins = drive_ch.coil_pins;
    got.busy = drive_ch.busy_res;
    got.pos = drive_ch.step_position;
    if (drive_expected.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("cycle %0d: unexpected drive beat a=%0d b=%0d pins=%b busy=%b pos=%0d",
                 cycle_count, got.dac_a, got.dac_b, got.pins, got.busy, $signed(got.pos));
      return;
    end
    want = drive_expected.pop_front();
    if (got.dac_a !== want.dac_a || got.dac_b !== want.dac_b || got.pins !== want.pins ||
        got.busy !== want.busy || got.pos !== want.pos) begin
      mismatches++;
      if (mismatches <= 10)
        $display("cycle %0d: expected %0d/%0d/%b/%b/%0d got %0d/%0d/%b/%b/%0d",
                 cycle_count, want.dac_a, want.dac_b, want.pins, want.busy,
                 $signed(want.pos), got.dac_a, got.dac_b, got.pins, got.busy,
                 $signed(got.pos));
    end
  endtask

  always @(posedge clk) begin : drive_sink
    int unsigned stall;
    if (!rst_n) begin
      drive_ch.ready <= 1'b0;
      sink_wait <= 0;
    end else if (drive_ch.valid && drive_ch.ready) begin
      check_drive_beat();
      stall = snk_calm ? 0 : $urandom_range(0, 9);
      drive_ch.ready <= (stall == 0);
      sink_wait <= stall;
    end else if (sink_wait > 1) begin
      sink_wait <= sink_wait - 1;
    end else begin
      sink_wait <= 0;
      drive_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_default_move();
    settle();
    send_cmd(smd_pkg::OP_TICK, 16'sd0);
    send_cmd(smd_pkg::OP_MOVE, 16'sd3);
    repeat (2) send_cmd(smd_pkg::OP_TICK, 16'sd0);
    // zero count cancels the move in progress
    send_cmd(smd_pkg::OP_MOVE, 16'sd0);
    send_cmd(smd_pkg::OP_TICK, 16'sd0);
  endtask

  task automatic test_field_extremes();
    settle();
    set_regs(24'd1, 8'd255, 20'd0);
    send_cmd(smd_pkg::OP_MOVE, 16'sh7FFF);
    repeat (2) send_cmd(smd_pkg::OP_TICK, 16'sh7FFF);
    send_cmd(smd_pkg::OP_MOVE, 16'sh8000);
    repeat (2) send_cmd(smd_pkg::OP_TICK, 16'sh8000);
    send_cmd(smd_pkg::OP_MOVE, -16'sd1);
    repeat (3) send_cmd(smd_pkg::OP_TICK, 16'sd0);
  endtask

  task automatic test_long_period_hold();
    settle();
    set_regs(24'hFFFFFF, 8'd0, 20'hFFFFF);
    send_cmd(smd_pkg::OP_MOVE, 16'sd1);
    repeat (2) send_cmd(smd_pkg::OP_TICK, 16'sd0);
    send_cmd(smd_pkg::OP_MOVE, 16'sd0);
  endtask

  task automatic test_zero_period();
    settle();
    set_regs(24'd0, 8'd128, 20'd2);
    send_cmd(smd_pkg::OP_MOVE, 16'sd2);
    repeat (5) send_cmd(smd_pkg::OP_TICK, 16'sd0);
    send_cmd(smd_pkg::OP_MOVE, -16'sd3);
    send_cmd(smd_pkg::OP_TICK, 16'sd0);
    // restart while a move is running
    send_cmd(smd_pkg::OP_MOVE, 16'sd1);
    send_cmd(smd_pkg::OP_TICK, 16'sd0);
  endtask

  task automatic test_random_moves();
    int phase, sent, cap, mag, k, eff;
    int unsigned pick;
    period_band_t band;
    logic [23:0] per;
    logic [7:0] amp;
    logic [19:0] hold;
    logic signed [15:0] steps;
    for (phase = 0; phase < 7; phase++) begin
      settle();
      pick = $urandom_range(0, 9);
      band = (pick < 6) ? PER_TINY : (pick < 9) ? PER_MID : PER_LARGE;
      case (band)
        PER_TINY: per = 24'($urandom_range(0, 6));
        PER_MID:  per = 24'($urandom_range(7, 60));
        default:  per = 24'($urandom_range(100, 400));
      endcase
      if ($urandom_range(0, 11) == 0) per = 24'hFFFFFF;
      pick = $urandom_range(0, 5);
      amp = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 254));
      hold = ($urandom_range(0, 9) == 0) ? 20'hFFFFF : 20'($urandom_range(0, 8));
      set_regs(per, amp, hold);
      src_calm = ($urandom_range(0, 3) == 0);
      snk_calm = ($urandom_range(0, 3) == 0);
      eff = (per == 0) ? 1 : int'(per);
      sent = 0;
      while (sent < 60) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) steps = 16'sd0;
        else if (pick == 1) steps = 16'($urandom);
        else if (pick == 2) steps = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else begin
          mag = int'($urandom_range(1, (band == PER_TINY) ? 3 : 1));
          steps = $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
        end
        mag = (steps < 0) ? -int'(steps) : int'(steps);
        cap = (eff > 1000) ? 40 : (mag + 1) * (eff + 1) + ((hold > 50) ? 0 : int'(hold)) + 4;
        if (cap > 150) cap = 150;
        if ($urandom_range(0, 9) == 0) cap = int'($urandom_range(1, cap));
        send_cmd(smd_pkg::OP_MOVE, steps);
        k = 0;
        while ((mtr_moving || mtr_holding) && k < cap) begin
          send_cmd(smd_pkg::OP_TICK, 16'($urandom));
          k++;
        end
        sent += 1 + k;
        repeat ($urandom_range(0, 3)) send_cmd(smd_pkg::OP_TICK, 16'($urandom));
      end
    end
    src_calm = 1'b0;
    snk_calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = smd_pkg::OP_TICK;
    cmd_ch.move_steps = '0;
    cfg_we = 1'b0;
    cfg_idx = smd_pkg::REG_STEP_PERIOD;
    cfg_wdata = '0;
    mtr_period = smd_pkg::PERIOD_RST;
    mtr_amp = smd_pkg::AMP_RST;
    mtr_hold = smd_pkg::HOLD_RST;
    mtr_moving = 1'b0;
    mtr_holding = 1'b0;
    mtr_fwd = 1'b1;
    mtr_left = '0;
    mtr_pos = '0;
    mtr_elapsed = '0;
    mtr_hold_cnt = '0;
    mtr_pins = '0;
    mtr_dac_a = '0;
    mtr_dac_b = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_move();
    test_field_extremes();
    test_long_period_hold();
    test_zero_period();
    test_random_moves();
    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && drive_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
